@@ rtl/rdsm_pkg.sv @@
// rdsm_pkg: shared types and constants for the dot-star pattern matcher
// holds item structs, register indexes and pattern character codes
// no dependencies

package rdsm_pkg;

    localparam int CHAR_W          = 8;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int COUNT_W         = 5;
    localparam int MASK_W          = 16;
    localparam int MAX_ELEMENTS_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STAR_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANY_MASK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 3'd4;

    localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_string;
        logic              empty_string;
    } in_item_t;

    typedef struct packed {
        logic matched;
        logic no_hope;
        logic string_done;
    } out_item_t;

endpackage

@@ rtl/regex_dot_star_matcher.sv @@
// regex_dot_star_matcher: whole-string matcher for literal and '.' elements, each
// optionally starred, with the subject streamed one byte per item
// depends on rdsm_pkg and rdsm_step
//
// usage
//   the pattern is written through cfg_wr_en / cfg_index / cfg_wr_data while idle:
//   index 0 chars 0..7, 1 chars 8..15, 2 star mask, 3 any mask, 4 element count
//   s_item carries one subject byte with end and empty flags; every item gives
//   exactly one m_item telling whether the bytes so far match the whole pattern,
//   whether no match is possible any more, and whether the string has ended
//   an item with the end or empty flag set returns the matcher to the start of a
//   new string
// timing
//   an item passes through the input register, then the closure and advance
//   logic into the result register
//   throughput is one item per cycle while m_ready is high, set by the update
//   of the reachable-position vector that each item reads and writes
// reset and stalls
//   aresetn (synchronous, active low) clears the pattern to empty, empties both
//   stages and sets only position zero reachable
//   while m_ready is low the result holds; one more item waits in the input
//   register, then s_ready drops

module regex_dot_star_matcher #(
    parameter int MAX_ELEMENTS = rdsm_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [rdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdsm_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  rdsm_pkg::in_item_t                s_item,

    output logic                              m_valid,
    input  logic                              m_ready,
    output rdsm_pkg::out_item_t               m_item
);

    logic [rdsm_pkg::CFG_DATA_W-1:0] chars_low_reg;
    logic [rdsm_pkg::CFG_DATA_W-1:0] chars_high_reg;
    logic [rdsm_pkg::MASK_W-1:0]     star_mask_reg;
    logic [rdsm_pkg::MASK_W-1:0]     any_mask_reg;
    logic [rdsm_pkg::COUNT_W-1:0]    element_count_reg;

    logic                 in_valid_reg;
    rdsm_pkg::in_item_t   in_item_reg;
    logic                 out_valid_reg;
    rdsm_pkg::out_item_t  out_item_reg;
    logic [MAX_ELEMENTS:0] state_reg;
    logic [MAX_ELEMENTS:0] state_next;

    rdsm_pkg::out_item_t  step_result;
    logic [MAX_ELEMENTS:0] step_state;
    logic                 out_load;
    logic                 in_load;

    assign out_load = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready  = ~in_valid_reg | out_load;
    assign in_load  = s_valid & s_ready;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg     <= '0;
            chars_high_reg    <= '0;
            star_mask_reg     <= '0;
            any_mask_reg      <= '0;
            element_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rdsm_pkg::CFG_CHARS_LOW: begin
                    chars_low_reg <= cfg_wr_data;
                end
                rdsm_pkg::CFG_CHARS_HIGH: begin
                    chars_high_reg <= cfg_wr_data;
                end
                rdsm_pkg::CFG_STAR_MASK: begin
                    star_mask_reg <= cfg_wr_data[rdsm_pkg::MASK_W-1:0];
                end
                rdsm_pkg::CFG_ANY_MASK: begin
                    any_mask_reg <= cfg_wr_data[rdsm_pkg::MASK_W-1:0];
                end
                rdsm_pkg::CFG_ELEMENT_COUNT: begin
                    element_count_reg <= cfg_wr_data[rdsm_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    rdsm_step #(.NUM_ELEM(MAX_ELEMENTS)) u_step (
        .state         (state_reg),
        .item          (in_item_reg),
        .chars         ({chars_high_reg, chars_low_reg}),
        .star_mask     (star_mask_reg),
        .any_mask      (any_mask_reg),
        .element_count (element_count_reg),
        .result        (step_result),
        .next_state    (step_state)
    );

    // back to the start position once a string ends
    always_comb begin
        state_next = state_reg;
        if (out_load) begin
            if (step_result.string_done) begin
                state_next = (MAX_ELEMENTS + 1)'(1);
            end else begin
                state_next = step_state;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= (MAX_ELEMENTS + 1)'(1);
        end else begin
            state_reg <= state_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg <= s_item;
        end
        if (out_load) begin
            out_item_reg <= step_result;
        end
    end

endmodule

@@ rtl/rdsm_closure.sv @@
// rdsm_closure: closes a set of pattern positions over skippable elements
// position k+1 becomes reachable when k is reachable and element k can be skipped
// depends on rdsm_pkg

module rdsm_closure #(
    parameter int NUM_ELEM = rdsm_pkg::MAX_ELEMENTS_DEF
) (
    input  logic [NUM_ELEM:0]   set_in,
    input  logic [NUM_ELEM-1:0] pass,
    output logic [NUM_ELEM:0]   set_out
);

    always_comb begin
        set_out    = set_in;
        for (int k = 0; k < NUM_ELEM; k++) begin
            set_out[k+1] = set_in[k+1] | (set_out[k] & pass[k]);
        end
    end

endmodule

@@ rtl/rdsm_step.sv @@
// rdsm_step: next reachable set and result flags for one subject byte
// decodes the pattern registers, closes the set, advances on the byte
// depends on rdsm_pkg and rdsm_closure

module rdsm_step #(
    parameter int NUM_ELEM = rdsm_pkg::MAX_ELEMENTS_DEF
) (
    input  logic [NUM_ELEM:0]                state,
    input  rdsm_pkg::in_item_t               item,
    input  logic [2*rdsm_pkg::CFG_DATA_W-1:0] chars,
    input  logic [rdsm_pkg::MASK_W-1:0]      star_mask,
    input  logic [rdsm_pkg::MASK_W-1:0]      any_mask,
    input  logic [rdsm_pkg::COUNT_W-1:0]     element_count,
    output rdsm_pkg::out_item_t              result,
    output logic [NUM_ELEM:0]                next_state
);

    localparam int NW = $clog2(NUM_ELEM + 1);

    logic [NW-1:0]       n;
    logic [NUM_ELEM:0]   pos_mask;
    logic [NUM_ELEM-1:0] active;
    logic [NUM_ELEM-1:0] elem_any;
    logic [NUM_ELEM-1:0] elem_skip;
    logic [NUM_ELEM-1:0] elem_star;
    logic [NUM_ELEM-1:0] pass;
    logic [NUM_ELEM-1:0] hit;
    logic [NUM_ELEM:0]   cur;
    logic [NUM_ELEM:0]   adv;
    logic [NUM_ELEM:0]   adv_closed;

    always_comb begin
        if (element_count > rdsm_pkg::COUNT_W'(NUM_ELEM)) begin
            n = NW'(NUM_ELEM);
        end else begin
            n = element_count[NW-1:0];
        end
    end

    always_comb begin
        for (int j = 0; j <= NUM_ELEM; j++) begin
            pos_mask[j] = (NW'(j) <= n);
        end
        for (int k = 0; k < NUM_ELEM; k++) begin
            active[k]    = (NW'(k) < n);
            elem_any[k]  = any_mask[k] | (chars[8*k +: 8] == rdsm_pkg::DOT_CHAR);
            elem_skip[k] = ~elem_any[k] & (chars[8*k +: 8] == rdsm_pkg::STAR_CHAR);
            elem_star[k] = star_mask[k];
            pass[k]      = active[k] & (elem_star[k] | elem_skip[k]);
        end
    end

    rdsm_closure #(.NUM_ELEM(NUM_ELEM)) u_close_cur (
        .set_in  (state & pos_mask),
        .pass    (pass),
        .set_out (cur)
    );

    always_comb begin
        adv = '0;
        for (int k = 0; k < NUM_ELEM; k++) begin
            hit[k] = cur[k] & active[k] & ~elem_skip[k]
                   & (elem_any[k] | (chars[8*k +: 8] == item.char_in));
            if (hit[k]) begin
                if (elem_star[k]) begin
                    adv[k] = 1'b1;
                end else begin
                    adv[k+1] = 1'b1;
                end
            end
        end
    end

    rdsm_closure #(.NUM_ELEM(NUM_ELEM)) u_close_adv (
        .set_in  (adv & pos_mask),
        .pass    (pass),
        .set_out (adv_closed)
    );

    always_comb begin
        next_state         = item.empty_string ? cur : adv_closed;
        result.matched     = next_state[n];
        result.no_hope     = (next_state == '0);
        result.string_done = item.end_of_string | item.empty_string;
    end

endmodule
